>>> rtl/oram_path_bucket_read_write_defines.svh
// assertion macros used by opbrw_back
`ifndef ORAM_PATH_BUCKET_READ_WRITE_DEFINES_SVH
`define ORAM_PATH_BUCKET_READ_WRITE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define OPB_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define OPB_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/opbrw_pkg.sv
package opbrw_pkg;
  localparam int SLOTS_DEF       = 4;
  localparam int PATH_DEPTH_DEF  = 16;
  localparam int BLOCK_WORDS_DEF = 8;
  localparam int MAX_OUT         = 8;

  localparam int KEY_W  = 32;
  localparam int PATH_W = 32;
  localparam int DATA_W = 64;
  localparam int IDX_W  = 3;
  localparam int DEP_W  = 4;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [DEP_W-1:0]    depth;
    logic [KEY_W-1:0]    blk_id;
    logic [PATH_W-1:0]   leaf_path;
    logic [IDX_W-1:0]    word_index;
    logic [DATA_W-1:0]   data_word;
  } cmd_t;

  typedef struct packed {
    logic                status;
    logic [DATA_W-1:0]   data_word_res;
    logic [IDX_W-1:0]    word_index_res;
    logic                last;
  } res_t;
endpackage

>>> rtl/opbrw_if.sv
interface opbrw_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/oram_path_bucket_read_write.sv
// channel  | dir | payload
// cmd      | in  | kind, depth, blk_id, leaf_path, word_index, data_word
// res      | out | status, data_word_res, word_index_res, last
//
// a write passes the front register, the queue, the scan and the result word
// a read does one block memory read per result word
// synchronous active-high reset clears slot tables, counts and pending state
// the block memory is not cleared; a hit may read words never written
// a stalled result holds the back part; the front and queue take words until full
module oram_path_bucket_read_write #(
  parameter int SLOTS       = opbrw_pkg::SLOTS_DEF,
  parameter int PATH_DEPTH  = opbrw_pkg::PATH_DEPTH_DEF,
  parameter int BLOCK_WORDS = opbrw_pkg::BLOCK_WORDS_DEF
) (
  input  logic clk,
  input  logic rst,
  opbrw_if.sink   cmd,
  opbrw_if.source res
);
  import opbrw_pkg::*;

  // front to queue, queue to back
  opbrw_if #(.T(cmd_t)) f2q ();
  opbrw_if #(.T(cmd_t)) q2b ();

  opbrw_front u_front (
    .clk(clk), .rst(rst), .cmd(cmd), .q(f2q)
  );

  opbrw_queue u_queue (
    .clk(clk), .rst(rst), .enq(f2q), .deq(q2b)
  );

  opbrw_back #(
    .SLOTS(SLOTS), .PATH_DEPTH(PATH_DEPTH), .BLOCK_WORDS(BLOCK_WORDS)
  ) u_back (
    .clk(clk), .rst(rst), .q(q2b), .res(res)
  );
endmodule

>>> rtl/opbrw_queue.sv
// short two-entry queue between the front and back parts
module opbrw_queue (
  input  logic clk,
  input  logic rst,
  opbrw_if.sink   enq,
  opbrw_if.source deq
);
  import opbrw_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_enq;
  logic       do_deq;

  assign enq.ready   = (fill != 2'd2);
  assign deq.valid   = (fill != 2'd0);
  assign deq.payload = mem[rd_ptr];
  assign do_enq      = enq.valid && enq.ready;
  assign do_deq      = deq.valid && deq.ready;

  always_ff @(posedge clk) begin
    if (do_enq) begin
      mem[wr_ptr] <= enq.payload;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_enq) wr_ptr <= ~wr_ptr;
      if (do_deq) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, do_enq} - {1'b0, do_deq};
    end
  end
endmodule

>>> rtl/opbrw_front.sv
// input stage: registers each word
module opbrw_front (
  input  logic clk,
  input  logic rst,
  opbrw_if.sink   cmd,
  opbrw_if.source q
);
  import opbrw_pkg::*;

  logic hold_valid;
  cmd_t hold;

  assign cmd.ready = !hold_valid || q.ready;
  assign q.valid   = hold_valid;
  assign q.payload = hold;

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      hold <= cmd.payload;
    end
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (cmd.ready) begin
      hold_valid <= cmd.valid;
    end
  end
endmodule

>>> rtl/opbrw_back.sv
// executor: slot scan, table update, block memory access, result sequencing
module opbrw_back #(
  parameter int SLOTS       = opbrw_pkg::SLOTS_DEF,
  parameter int PATH_DEPTH  = opbrw_pkg::PATH_DEPTH_DEF,
  parameter int BLOCK_WORDS = opbrw_pkg::BLOCK_WORDS_DEF
) (
  input  logic clk,
  input  logic rst,
  opbrw_if.sink   q,
  opbrw_if.source res
);
  import opbrw_pkg::*;
  `include "oram_path_bucket_read_write_defines.svh"

  localparam int SL_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DI_W       = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int READ_WORDS = (BLOCK_WORDS < MAX_OUT) ? BLOCK_WORDS : MAX_OUT;
  localparam int RW_W       = $clog2(READ_WORDS + 1);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int MEM_D      = PATH_DEPTH * SLOTS * BLOCK_WORDS;
  localparam int MA_W       = (MEM_D > 1) ? $clog2(MEM_D) : 1;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WRITE, S_RD_ISSUE, S_RD_OUT} state_t;

  state_t state;

  // one row of keys and presence bits per bucket
  logic [SLOTS-1:0][KEY_W-1:0] slot_keys     [PATH_DEPTH];
  logic [SLOTS-1:0]            slot_present  [PATH_DEPTH];
  logic [CNT_W-1:0]            bucket_counts [PATH_DEPTH];
  logic [DATA_W-1:0]           block_store   [MEM_D];

  logic [SL_W-1:0]   pending_slot;
  logic              pending_ok;
  logic [DEP_W-1:0]  pending_depth;

  cmd_t              cur;
  logic              hit;
  logic [SL_W-1:0]   hit_slot;
  logic [RW_W-1:0]   rd_word;
  logic [DATA_W-1:0] rd_data;
  logic              out_valid;
  res_t              out_r;

  // scan of the addressed bucket, one small bucket wide
  logic [SLOTS-1:0]            match_vec;
  logic [SLOTS-1:0]            empty_vec;
  logic                        any_empty;
  logic [SL_W-1:0]             first_empty;
  logic                        any_match;
  logic [SL_W-1:0]             last_match;
  logic [CNT_W-1:0]            match_cnt;
  logic                        depth_ok;
  logic [DI_W-1:0]             dep_idx;
  logic [SLOTS-1:0][KEY_W-1:0] key_row;
  logic [SLOTS-1:0]            present_row;
  logic [CNT_W-1:0]            cur_count;
  logic                        wr0_ok;
  logic                        wr_later_ok;
  logic                        wr_en;
  logic [MA_W-1:0]             wr_addr;
  logic [MA_W-1:0]             rd_addr;
  logic                        pend_dep_ok;
  logic                        last_take;

  assign depth_ok    = (int'(cur.depth) < PATH_DEPTH);
  assign dep_idx     = DI_W'(cur.depth);
  assign key_row     = slot_keys[dep_idx];
  assign present_row = slot_present[dep_idx];
  assign cur_count   = depth_ok ? bucket_counts[dep_idx] : '0;

  always_comb begin
    match_vec   = '0;
    empty_vec   = '0;
    any_empty   = 1'b0;
    first_empty = '0;
    any_match   = 1'b0;
    last_match  = '0;
    match_cnt   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match_vec[i] = depth_ok && present_row[i] && (key_row[i] == cur.blk_id);
      empty_vec[i] = depth_ok && !present_row[i];
      if (match_vec[i]) begin
        any_match  = 1'b1;
        last_match = SL_W'(i);
        match_cnt  = match_cnt + CNT_W'(1);
      end
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (empty_vec[i]) begin
        any_empty   = 1'b1;
        first_empty = SL_W'(i);
      end
    end
  end

  // word 0 claims the first empty slot, later words go to the remembered slot
  assign wr0_ok      = (cur.blk_id != '0) && (int'(cur_count) < SLOTS) && any_empty;
  assign wr_later_ok = pending_ok && (int'(cur.word_index) < BLOCK_WORDS);
  assign wr_en       = (state == S_SCAN) && (cur.kind == KIND_WRITE)
                       && ((cur.word_index == '0) ? wr0_ok : wr_later_ok);
  assign wr_addr     = (cur.word_index == '0)
                       ? MA_W'((int'(cur.depth) * SLOTS + int'(first_empty)) * BLOCK_WORDS)
                       : MA_W'((int'(pending_depth) * SLOTS + int'(pending_slot))
                               * BLOCK_WORDS + int'(cur.word_index));
  assign rd_addr     = MA_W'((int'(cur.depth) * SLOTS + int'(hit_slot)) * BLOCK_WORDS
                             + int'(rd_word));

  assign pend_dep_ok = (int'(pending_depth) < PATH_DEPTH);
  assign last_take   = out_valid && res.ready && out_r.last;

  assign q.ready     = (state == S_IDLE);
  assign res.valid   = out_valid;
  assign res.payload = out_r;

  // block memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      block_store[wr_addr] <= cur.data_word;
    end
    if (state == S_RD_ISSUE) begin
      rd_data <= block_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      for (int d = 0; d < PATH_DEPTH; d++) begin
        slot_keys[d]     <= '0;
        slot_present[d]  <= '0;
        bucket_counts[d] <= '0;
      end
      pending_slot  <= '0;
      pending_ok    <= 1'b0;
      pending_depth <= '0;
      out_valid     <= 1'b0;
      hit           <= 1'b0;
      hit_slot      <= '0;
      rd_word       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q.valid) begin
            cur   <= q.payload;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cur.kind == KIND_READ) begin
            hit      <= any_match;
            hit_slot <= last_match;
            rd_word  <= '0;
            if (any_match) begin
              // every matching slot is removed, count drops once per match
              slot_present[dep_idx] <= present_row & ~match_vec;
              for (int i = 0; i < SLOTS; i++) begin
                if (match_vec[i]) begin
                  slot_keys[dep_idx][i] <= '0;
                end
              end
              bucket_counts[dep_idx] <= (cur_count > match_cnt) ? cur_count - match_cnt : '0;
            end
            state <= S_RD_ISSUE;
          end else begin
            out_r.data_word_res  <= '0;
            out_r.word_index_res <= cur.word_index;
            out_r.last           <= 1'b1;
            if (cur.word_index == '0) begin
              pending_ok   <= wr0_ok;
              out_r.status <= wr0_ok ? ST_OK : ST_FAIL;
              if (wr0_ok) begin
                slot_keys[dep_idx][first_empty]    <= cur.blk_id;
                slot_present[dep_idx][first_empty] <= 1'b1;
                bucket_counts[dep_idx]             <= cur_count + CNT_W'(1);
                pending_slot  <= first_empty;
                pending_depth <= cur.depth;
              end
            end else begin
              out_r.status <= wr_later_ok ? ST_OK : ST_FAIL;
            end
            out_valid <= 1'b1;
            state     <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (res.ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_RD_ISSUE: begin
          state <= S_RD_OUT;
        end
        S_RD_OUT: begin
          if (!out_valid) begin
            out_r.status         <= hit ? ST_OK : ST_FAIL;
            out_r.data_word_res  <= hit ? rd_data : '0;
            out_r.word_index_res <= IDX_W'(rd_word);
            out_r.last           <= (int'(rd_word) == READ_WORDS - 1);
            out_valid            <= 1'b1;
          end else if (res.ready) begin
            out_valid <= 1'b0;
            if (out_r.last) begin
              state <= S_IDLE;
            end else begin
              rd_word <= rd_word + RW_W'(1);
              state   <= S_RD_ISSUE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `OPB_ASSERT_IMP(a_busy_no_take, clk, rst, state != S_IDLE, !q.ready, "took word while busy")
  `OPB_ASSERT_IMP(a_pend_rng, clk, rst, pending_ok, pend_dep_ok, "bad pending depth")
  `OPB_ASSERT_NXT(a_last_idle, clk, rst, last_take, state == S_IDLE, "no idle after last")
endmodule

>>> tb/oram_path_bucket_read_write_chk.sv
module oram_path_bucket_read_write_chk (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  logic cmd_ready,
  input  opbrw_pkg::cmd_t cmd_word,
  input  logic res_valid,
  input  logic res_ready,
  input  opbrw_pkg::res_t res_word,
  output int   errors,
  output int   pending_words
);
  import opbrw_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam int PDEP  = PATH_DEPTH_DEF;
  localparam int BW    = BLOCK_WORDS_DEF;
  localparam int RW    = (BW < MAX_OUT) ? BW : MAX_OUT;

  logic [KEY_W-1:0]  keys [PDEP*SLOTS];
  logic              present [PDEP*SLOTS];
  int                counts [PDEP];
  logic [DATA_W-1:0] blocks [PDEP*SLOTS*BW];
  int                wr_slot;
  int                wr_depth;
  logic              wr_ok;
  res_t              expected_q[$];

  // bucket model update for one accepted command
  task automatic apply_cmd(input cmd_t c);
    int s;
    int hit_s;
    logic ok;
    res_t r;
    hit_s = -1;
    ok = 1'b0;
    if (c.kind == KIND_READ) begin
      if (c.depth < PDEP) begin
        for (int i = 0; i < SLOTS; i++) begin
          s = c.depth * SLOTS + i;
          if (present[s] && keys[s] == c.blk_id) begin
            hit_s = s;
            keys[s] = '0;
            present[s] = 1'b0;
            if (counts[c.depth] > 0) counts[c.depth]--;
          end
        end
      end
      for (int w = 0; w < RW; w++) begin
        r.status = (hit_s >= 0) ? ST_OK : ST_FAIL;
        r.data_word_res = (hit_s >= 0) ? blocks[hit_s*BW + w] : '0;
        r.word_index_res = w[IDX_W-1:0];
        r.last = (w == RW - 1);
        expected_q.push_back(r);
      end
    end else begin
      if (c.word_index == 0) begin
        wr_ok = 1'b0;
        if (c.depth < PDEP && c.blk_id != 0 && counts[c.depth] < SLOTS) begin
          for (int i = 0; i < SLOTS; i++) begin
            s = c.depth * SLOTS + i;
            if (!ok && !present[s]) begin
              keys[s] = c.blk_id;
              present[s] = 1'b1;
              blocks[s*BW] = c.data_word;
              counts[c.depth]++;
              wr_slot = i;
              wr_depth = c.depth;
              wr_ok = 1'b1;
              ok = 1'b1;
            end
          end
        end
      end else if (wr_ok && c.word_index < BW) begin
        blocks[(wr_depth*SLOTS + wr_slot)*BW + c.word_index] = c.data_word;
        ok = 1'b1;
      end
      r.status = ok ? ST_OK : ST_FAIL;
      r.data_word_res = '0;
      r.word_index_res = c.word_index;
      r.last = 1'b1;
      expected_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      for (int i = 0; i < PDEP*SLOTS; i++) begin
        keys[i] = '0;
        present[i] = 1'b0;
      end
      for (int d = 0; d < PDEP; d++) counts[d] = 0;
      wr_slot = 0;
      wr_depth = 0;
      wr_ok = 1'b0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %p", res_word);
        end else begin
          e = expected_q.pop_front();
          if (e !== res_word) begin
            errors++;
            if (errors <= 10) $display("result word: expected %p actual %p", e, res_word);
          end
        end
      end
      if (cmd_valid && cmd_ready) apply_cmd(cmd_word);
    end
    pending_words = expected_q.size();
  end
endmodule

>>> tb/tb_oram_path_bucket_read_write.sv
module tb_oram_path_bucket_read_write;
  import opbrw_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending_words;
  int   hold_cycles = 0;
  bit   hold_req = 1'b0;
  bit   hold_done = 1'b0;
  bit   calm = 1'b0;

  opbrw_if #(.T(cmd_t)) cmd ();
  opbrw_if #(.T(res_t)) res ();

  oram_path_bucket_read_write uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  oram_path_bucket_read_write_chk chk (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .cmd_word      (cmd.payload),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_word      (res.payload),
    .errors        (errors),
    .pending_words (pending_words)
  );

  always #5 clk = ~clk;

  // keys of nonzero blocks whose words were all sent, so reads never hit unwritten words
  logic [KEY_W-1:0] full_keys[$];

  // sender: drives one word and holds it until accepted
  task automatic send(input cmd_t c);
    while (!calm && $urandom_range(99) < 20) begin
      cmd.valid <= 1'b0;
      @(negedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.payload <= c;
    do @(posedge clk); while (!cmd.ready);
    @(negedge clk);
  endtask

  // write all words of a block; a failed word 0 makes later words fail too
  task automatic write_block(input logic [DEP_W-1:0] d, input logic [KEY_W-1:0] k);
    cmd_t c;
    for (int w = 0; w < BLOCK_WORDS_DEF; w++) begin
      c.kind = KIND_WRITE;
      c.depth = d;
      c.blk_id = k;
      c.leaf_path = $urandom;
      c.word_index = IDX_W'(w);
      c.data_word = {$urandom, $urandom};
      send(c);
    end
    if (k != 0) full_keys.push_back(k);
  endtask

  task automatic read_block(input logic [DEP_W-1:0] d, input logic [KEY_W-1:0] k);
    cmd_t c;
    c.kind = KIND_READ;
    c.depth = d;
    c.blk_id = k;
    c.leaf_path = $urandom;
    c.word_index = IDX_W'($urandom);
    c.data_word = {$urandom, $urandom};
    send(c);
  endtask

  // receiver: random stalls, plus one long hold-off counted here
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      res.ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles == 199) hold_done <= 1'b1;
    end else begin
      res.ready <= calm ? 1'b1 : ($urandom_range(99) >= 20);
    end
  end

  initial begin
    cmd_t c;
    int   wait_cnt;
    logic [KEY_W-1:0] k;
    cmd.valid = 1'b0;
    cmd.payload = '0;
    res.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, full bucket, zero key, a repeated read, a stray later word
    write_block(4'd0, 32'hffff_ffff);
    write_block(4'd15, 32'h1);
    for (int i = 0; i < 4; i++) write_block(4'd7, 32'h100 + i);
    write_block(4'd7, 32'h200);              // bucket full
    write_block(4'd3, 32'h0);                // zero key
    c = '0; c.kind = KIND_WRITE; c.word_index = 3'd5; c.data_word = '1;
    send(c);                                 // later word without pending block
    read_block(4'd0, 32'hffff_ffff);
    read_block(4'd0, 32'hffff_ffff);         // now a miss
    read_block(4'd15, 32'h1);
    read_block(4'd7, 32'h102);
    read_block(4'd9, 32'h0);                 // miss on empty bucket

    // long receiver hold-off while the sender keeps pushing
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) read_block(4'd7, 32'h100 + i);

    // random: mostly whole blocks and reads of stored keys, some noise
    for (int n = 0; n < 110; n++) begin
      calm = (n >= 50 && n < 65);
      case ($urandom_range(9))
        0, 1, 2, 3: write_block(DEP_W'($urandom_range(15)), $urandom_range(1, 40));
        4, 5, 6: begin
          if (full_keys.size() > 0) begin
            k = full_keys[$urandom_range(full_keys.size() - 1)];
            read_block(DEP_W'($urandom_range(15)), k);
          end else begin
            read_block(DEP_W'($urandom_range(15)), $urandom);
          end
        end
        7: read_block(DEP_W'($urandom_range(15)), $urandom);
        default: begin
          // stray later word
          c.kind = KIND_WRITE;
          c.depth = DEP_W'($urandom);
          c.blk_id = $urandom;
          c.leaf_path = $urandom;
          c.word_index = IDX_W'($urandom_range(1, 7));
          c.data_word = {$urandom, $urandom};
          send(c);
        end
      endcase
    end
    cmd.valid <= 1'b0;
    calm = 1'b0;

    wait_cnt = 0;
    while (pending_words != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_words == 0) begin
      $display("oram_path_bucket_read_write: match");
    end else begin
      $display("oram_path_bucket_read_write: mismatch");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("oram_path_bucket_read_write: mismatch");
    $finish;
  end
endmodule

>>> oram_path_bucket_read_write.f
+incdir+rtl
rtl/opbrw_pkg.sv
rtl/opbrw_if.sv
rtl/opbrw_queue.sv
rtl/opbrw_front.sv
rtl/opbrw_back.sv
rtl/oram_path_bucket_read_write.sv
tb/oram_path_bucket_read_write_chk.sv
tb/tb_oram_path_bucket_read_write.sv
